[src/output_driver_feedback_diagnosis_core_assert.svh]
// ----------------------------------------------------------------------------
// Output driver feedback diagnosis: assertion macros
// Shared macros for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef OUTPUT_DRIVER_FEEDBACK_DIAGNOSIS_CORE_ASSERT_SVH
`define OUTPUT_DRIVER_FEEDBACK_DIAGNOSIS_CORE_ASSERT_SVH

// Checked only while the block is out of reset.
`define ODFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ODFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/odfd_pkg.sv]
// ----------------------------------------------------------------------------
// Output driver feedback diagnosis: package
// Codes, item layouts and per-channel state types shared by the block.
// ----------------------------------------------------------------------------
package odfd_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int IN_W             = 16;
  localparam int OUT_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 64;
  localparam int MASK_W           = 8;
  localparam int CNT_W            = 8;

  localparam logic [2:0] CMD_SET_STATE = 3'd0;
  localparam logic [2:0] CMD_DIAGNOSE  = 3'd1;
  localparam logic [2:0] CMD_DECODE    = 3'd2;
  localparam logic [2:0] CMD_SET_FAULT = 3'd3;
  localparam logic [2:0] CMD_ENABLE    = 3'd4;

  localparam logic [1:0] REQ_OFF      = 2'd0;
  localparam logic [1:0] REQ_ON       = 2'd1;
  localparam logic [1:0] REQ_PREVIOUS = 2'd2;
  localparam logic [1:0] REQ_INVALID  = 2'd3;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BAD_PARAM   = 2'd1;
  localparam logic [1:0] STATUS_NOT_ENABLED = 2'd2;

  localparam logic [2:0] FLT_NOT_TESTED = 3'd0;
  localparam logic [2:0] FLT_NONE       = 3'd1;
  localparam logic [2:0] FLT_OPEN_GND   = 3'd2;
  localparam logic [2:0] FLT_OPEN_BAT   = 3'd3;
  localparam logic [2:0] FLT_SHORT_BAT  = 3'd4;
  localparam logic [2:0] FLT_SHORT_GND  = 3'd5;
  localparam logic [2:0] FLT_OPEN_LOAD  = 3'd6;

  localparam logic [2:0] FS_NO_FAULT     = 3'd0;
  localparam logic [2:0] FS_UNTESTED_NF  = 3'd1;
  localparam logic [2:0] FS_ON           = 3'd2;
  localparam logic [2:0] FS_OFF          = 3'd3;
  localparam logic [2:0] FS_ALL          = 3'd4;
  localparam logic [2:0] FS_UNTESTED_ON  = 3'd5;
  localparam logic [2:0] FS_UNTESTED_OFF = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_CMD_ACTIVE_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FBK_ACTIVE_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SIDE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE       = 2'd3;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 64'h0303_0303_0303_0303;

  // Input item, first field in the highest bits.
  typedef struct packed {
    logic       enable;
    logic [2:0] fault_code_in;
    logic [2:0] fault_state_in;
    logic       feedback_level;
    logic [1:0] requested_state;
    logic [2:0] channel;
    logic [2:0] command;
  } in_item_t;

  // Result item, first field in the highest bits.
  typedef struct packed {
    logic       diag_data_state;
    logic [2:0] diag_data;
    logic [2:0] fault_state_out;
    logic [2:0] fault_out;
    logic       commanded_state;
    logic       output_on;
    logic       pin_level;
    logic       pin_write;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic             out_state;
    logic             pin_state;
    logic [2:0]       last_fault;
    logic [CNT_W-1:0] debounce_count;
    logic [2:0]       fault_state;
    logic [2:0]       decoded_fault;
    logic             decoded_state;
    logic             enabled;
  } chan_state_t;

  typedef struct packed {
    logic             cmd_active_low;
    logic             fbk_active_low;
    logic             high_side;
    logic [CNT_W-1:0] limit;
  } chan_cfg_t;

  localparam chan_state_t CHAN_RESET = '{
    out_state:      1'b0,
    pin_state:      1'b0,
    last_fault:     FLT_NOT_TESTED,
    debounce_count: '0,
    fault_state:    FS_UNTESTED_NF,
    decoded_fault:  FLT_NOT_TESTED,
    decoded_state:  1'b0,
    enabled:        1'b1
  };

endpackage

[src/odfd_chan_logic.sv]
// ----------------------------------------------------------------------------
// Output driver feedback diagnosis: channel command logic
// Computes the next state of the addressed channel and the result item.
// ----------------------------------------------------------------------------
module odfd_chan_logic (
  input  odfd_pkg::in_item_t    item,
  input  odfd_pkg::chan_state_t cur,
  input  odfd_pkg::chan_cfg_t   ccfg,
  output odfd_pkg::chan_state_t nxt,
  output odfd_pkg::result_t     res
);

  logic                       st;
  logic                       fbk_on;
  logic [2:0]                 nf;
  logic [odfd_pkg::CNT_W-1:0] cnt;
  logic [1:0]                 status;
  logic                       wrote;
  logic [2:0]                 fault;

  assign fbk_on = item.feedback_level ^ ccfg.fbk_active_low;
  assign cnt    = cur.debounce_count + odfd_pkg::CNT_W'(1);

  always_comb begin
    nxt    = cur;
    status = odfd_pkg::STATUS_OK;
    wrote  = 1'b0;
    fault  = odfd_pkg::FLT_NOT_TESTED;
    st     = cur.out_state;
    nf     = odfd_pkg::FLT_NONE;
    case (item.command)
      odfd_pkg::CMD_SET_STATE: begin
        if (!cur.enabled) begin
          status = odfd_pkg::STATUS_NOT_ENABLED;
        end else if (item.requested_state == odfd_pkg::REQ_INVALID) begin
          status = odfd_pkg::STATUS_BAD_PARAM;
        end else begin
          if (item.requested_state != odfd_pkg::REQ_PREVIOUS) begin
            st = item.requested_state[0];
            if (cur.out_state != st) begin
              nxt.debounce_count = '0;
            end
            nxt.out_state = st;
          end
          nxt.pin_state = st ^ ccfg.cmd_active_low;
          wrote         = 1'b1;
        end
      end
      odfd_pkg::CMD_DIAGNOSE: begin
        if (cur.enabled) begin
          if (fbk_on == cur.out_state) begin
            nf = odfd_pkg::FLT_NONE;
          end else if (!cur.out_state) begin
            nf = ccfg.high_side ? odfd_pkg::FLT_OPEN_BAT : odfd_pkg::FLT_OPEN_GND;
          end else begin
            nf = ccfg.high_side ? odfd_pkg::FLT_SHORT_GND : odfd_pkg::FLT_SHORT_BAT;
          end
          if (cur.last_fault != nf) begin
            if (cnt == ccfg.limit) begin
              nxt.last_fault     = nf;
              nxt.debounce_count = '0;
            end else begin
              nxt.debounce_count = cnt;
            end
          end else begin
            nxt.debounce_count = '0;
          end
          fault = nxt.last_fault;
        end
      end
      odfd_pkg::CMD_DECODE: begin
        nxt.fault_state   = item.fault_state_in;
        nxt.decoded_state = cur.out_state;
        case (item.fault_state_in) inside
          odfd_pkg::FS_NO_FAULT: nxt.decoded_fault = odfd_pkg::FLT_NONE;
          odfd_pkg::FS_ON, odfd_pkg::FS_OFF, odfd_pkg::FS_ALL:
            nxt.decoded_fault = cur.last_fault;
          default: nxt.decoded_fault = odfd_pkg::FLT_NOT_TESTED;
        endcase
      end
      odfd_pkg::CMD_SET_FAULT: begin
        case (item.fault_code_in)
          odfd_pkg::FLT_OPEN_LOAD: nxt.fault_state = odfd_pkg::FS_UNTESTED_ON;
          odfd_pkg::FLT_SHORT_GND: begin
            nxt.fault_state = ccfg.high_side ? odfd_pkg::FS_UNTESTED_ON
                                             : odfd_pkg::FS_UNTESTED_OFF;
          end
          odfd_pkg::FLT_SHORT_BAT: begin
            nxt.fault_state = ccfg.high_side ? odfd_pkg::FS_UNTESTED_OFF
                                             : odfd_pkg::FS_UNTESTED_ON;
          end
          default: status = odfd_pkg::STATUS_BAD_PARAM;
        endcase
      end
      odfd_pkg::CMD_ENABLE: nxt.enabled = item.enable;
      default: status = odfd_pkg::STATUS_BAD_PARAM;
    endcase
  end

  always_comb begin
    res.status          = status;
    res.pin_write       = wrote;
    res.pin_level       = nxt.pin_state;
    res.output_on       = nxt.pin_state ^ ccfg.cmd_active_low;
    res.commanded_state = nxt.out_state;
    res.fault_out       = fault;
    res.fault_state_out = nxt.fault_state;
    res.diag_data       = nxt.decoded_fault;
    res.diag_data_state = nxt.decoded_state;
  end

endmodule

[src/output_driver_feedback_diagnosis_core.sv]
// ----------------------------------------------------------------------------
// Output driver feedback diagnosis core
// Pipeline: input register, then result register; the channel update is one
// pass of logic between them. Throughput: one item per cycle unless out_tready
// stalls the result register, limited by the single per-channel state write.
// Reset: synchronous active-low rst_n clears the valid flags, the config
// registers and all channel state at once; items are accepted after release.
// ----------------------------------------------------------------------------
module output_driver_feedback_diagnosis_core #(
  parameter int NUM_CHANNELS = odfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // command, channel, requested_state, feedback_level, fault_state_in,
  // fault_code_in, enable
  input  logic [odfd_pkg::IN_W-1:0]       in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status, pin_write, pin_level, output_on, commanded_state, fault_out,
  // fault_state_out, diag_data, diag_data_state
  output logic [odfd_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [odfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [odfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [odfd_pkg::MASK_W-1:0]     cmd_al_r;
  logic [odfd_pkg::MASK_W-1:0]     fbk_al_r;
  logic [odfd_pkg::MASK_W-1:0]     high_side_r;
  logic [odfd_pkg::CFG_DATA_W-1:0] debounce_r;

  odfd_pkg::chan_state_t chan_r [NUM_CHANNELS];

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  odfd_pkg::in_item_t    s1_item_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  odfd_pkg::result_t     out_data_r;
  odfd_pkg::result_t     out_data_nxt;

  logic                  advance;
  logic                  ch_ok;
  logic [CH_IDX_W-1:0]   idx;
  odfd_pkg::chan_state_t cur;
  odfd_pkg::chan_state_t nxt;
  odfd_pkg::chan_cfg_t   ccfg;
  odfd_pkg::result_t     res;

  assign cfg_ready  = 1'b1;
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ch_ok = {1'b0, s1_item_r.channel} < 4'(NUM_CHANNELS);
  assign idx   = s1_item_r.channel[CH_IDX_W-1:0];
  assign cur   = chan_r[idx];

  assign ccfg.cmd_active_low = cmd_al_r[s1_item_r.channel];
  assign ccfg.fbk_active_low = fbk_al_r[s1_item_r.channel];
  assign ccfg.high_side      = high_side_r[s1_item_r.channel];
  assign ccfg.limit          = debounce_r[{s1_item_r.channel, 3'b000} +: odfd_pkg::CNT_W];

  odfd_chan_logic u_chan (
    .item (s1_item_r),
    .cur  (cur),
    .ccfg (ccfg),
    .nxt  (nxt),
    .res  (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt = res;
    if (!ch_ok) begin
      out_data_nxt        = '0;
      out_data_nxt.status = odfd_pkg::STATUS_BAD_PARAM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= odfd_pkg::in_item_t'(in_tdata);
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_r[i] <= odfd_pkg::CHAN_RESET;
      end
    end else if (advance && ch_ok) begin
      chan_r[idx] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_al_r    <= '0;
      fbk_al_r    <= '0;
      high_side_r <= '0;
      debounce_r  <= odfd_pkg::DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        odfd_pkg::CFG_CMD_ACTIVE_LOW: cmd_al_r    <= cfg_data[odfd_pkg::MASK_W-1:0];
        odfd_pkg::CFG_FBK_ACTIVE_LOW: fbk_al_r    <= cfg_data[odfd_pkg::MASK_W-1:0];
        odfd_pkg::CFG_HIGH_SIDE:      high_side_r <= cfg_data[odfd_pkg::MASK_W-1:0];
        odfd_pkg::CFG_DEBOUNCE:       debounce_r  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[src/odfd_checker.sv]
// ----------------------------------------------------------------------------
// Output driver feedback diagnosis: port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "output_driver_feedback_diagnosis_core_assert.svh"

module odfd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [odfd_pkg::OUT_W-1:0] out_tdata
);

  odfd_pkg::result_t res;

  assign res = odfd_pkg::result_t'(out_tdata);

  `ODFD_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_tvalid, "result valid after reset")
  `ODFD_ASSERT(a_stall_holds, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `ODFD_ASSERT(a_write_only_ok, out_tvalid && res.pin_write |-> res.status == odfd_pkg::STATUS_OK, "pin written with error status")
  `ODFD_ASSERT(a_disabled_no_fault, out_tvalid && res.status == odfd_pkg::STATUS_NOT_ENABLED |-> res.fault_out == odfd_pkg::FLT_NOT_TESTED && !res.pin_write, "disabled channel reported activity")

endmodule

bind output_driver_feedback_diagnosis_core odfd_checker u_odfd_checker (.*);
